@@ rtl/apa102_pkg.sv @@
// ----------------------------------------------------------------------------
// apa102_pkg: shared types, constants and tables of the LED strip frame driver
// Holds the request and result structs, the control word of the sequencer,
// the control program and the color palette.
// ----------------------------------------------------------------------------
package apa102_pkg;

  // Frame store size and derived widths
  localparam int MAX_LEDS = 32;
  localparam int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W    = 6;   // width of led_count, holds any count up to MAX_LEDS
  localparam int STEP_W   = 3;

  localparam logic [7:0]  BRIGHT_MARK = 8'hE0;
  localparam logic [31:0] START_WORD  = 32'h0000_0000;
  localparam logic [31:0] END_WORD    = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

  // Palette codes with fixed colors
  localparam logic [3:0] PAL_OFF = 4'd10;

  // One request
  typedef struct packed {
    logic       req_type;
    logic       use_palette;
    logic [4:0] led_index;
    logic [3:0] palette_code;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] bright_level;
  } req_t;

  // One emitted frame
  typedef struct packed {
    logic [31:0] frame_word;
    logic        last_frame;
  } rsp_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_START,
    C_PTR_END,
    C_REQ_ALL,
    C_CLEAN
  } cond_t;

  // Pointer operations
  typedef enum logic [1:0] {
    P_HOLD,
    P_LOAD,
    P_CLEAR,
    P_INC
  } ptr_op_t;

  // Frame to emit
  typedef enum logic [1:0] {
    E_NONE,
    E_START,
    E_DATA,
    E_END
  } emit_t;

  // Program steps
  typedef enum logic [STEP_W-1:0] {
    S_IDLE  = 3'd0,
    S_READ  = 3'd1,
    S_STORE = 3'd2,
    S_CHECK = 3'd3,
    S_HEAD  = 3'd4,
    S_FETCH = 3'd5,
    S_SEND  = 3'd6,
    S_TAIL  = 3'd7
  } step_t;

  // Control word
  typedef struct packed {
    cond_t   cond;
    step_t   target;
    ptr_op_t ptr_op;
    logic    latch;
    logic    store;
    logic    set_clean;
    emit_t   emit;
  } ctrl_t;

  // Status returned by the datapath
  typedef struct packed {
    logic start;
    logic ptr_end;
    logic req_all;
    logic clean;
  } status_t;

  // Control program
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t cw;
    cw = '{cond: C_NONE, target: S_IDLE, ptr_op: P_HOLD, latch: 1'b0,
           store: 1'b0, set_clean: 1'b0, emit: E_NONE};
    unique case (step)
      // wait for a request, take it in
      S_IDLE: begin
        cw.cond = C_NO_START; cw.target = S_IDLE;
        cw.ptr_op = P_LOAD; cw.latch = 1'b1;
      end
      // leave the update loop past the active count, else read the entry
      S_READ: begin
        cw.cond = C_PTR_END; cw.target = S_CHECK;
      end
      // write back a changed word, loop on set-all
      S_STORE: begin
        cw.cond = C_REQ_ALL; cw.target = S_READ;
        cw.ptr_op = P_INC; cw.store = 1'b1;
      end
      // skip the flush when the store is clean
      S_CHECK: begin
        cw.cond = C_CLEAN; cw.target = S_IDLE; cw.ptr_op = P_CLEAR;
      end
      S_HEAD: begin
        cw.emit = E_START; cw.set_clean = 1'b1;
      end
      S_FETCH: begin
        cw.cond = C_PTR_END; cw.target = S_TAIL;
      end
      S_SEND: begin
        cw.cond = C_ALWAYS; cw.target = S_FETCH;
        cw.ptr_op = P_INC; cw.emit = E_DATA;
      end
      S_TAIL: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE; cw.emit = E_END;
      end
      default: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

  // Palette color as {blue, green, red}
  function automatic logic [23:0] palette_bgr(input logic [3:0] code);
    logic [23:0] bgr;
    case (code)
      4'd0:    bgr = {8'd0,   8'd0,   8'd255};
      4'd1:    bgr = {8'd0,   8'd255, 8'd0};
      4'd2:    bgr = {8'd255, 8'd0,   8'd0};
      4'd3:    bgr = {8'd0,   8'd40,  8'd255};
      4'd4:    bgr = {8'd0,   8'd230, 8'd255};
      4'd5:    bgr = {8'd0,   8'd170, 8'd255};
      4'd6:    bgr = {8'd255, 8'd0,   8'd180};
      4'd7:    bgr = {8'd200, 8'd200, 8'd0};
      4'd8:    bgr = {8'd200, 8'd0,   8'd200};
      4'd9:    bgr = {8'd40,  8'd40,  8'd250};
      PAL_OFF: bgr = {8'd0,   8'd0,   8'd0};
      default: bgr = {8'd200, 8'd200, 8'd200};
    endcase
    return bgr;
  endfunction

  // LED word from a request
  function automatic logic [31:0] build_word(input req_t r);
    logic [23:0] bgr;
    bgr = r.use_palette ? palette_bgr(r.palette_code)
                        : {r.blue_level, r.green_level, r.red_level};
    return {BRIGHT_MARK | r.bright_level, bgr};
  endfunction

endpackage

@@ rtl/apa102_ram.sv @@
// ----------------------------------------------------------------------------
// apa102_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apa102_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/apa102_useq.sv @@
// ----------------------------------------------------------------------------
// apa102_useq: control sequencer
// Step counter over the control program, with conditional jumps on status.
// ----------------------------------------------------------------------------
module apa102_useq import apa102_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl,
  output logic    busy
);

  step_t step;
  step_t step_next;
  logic  taken;

  // Decode the current step
  always_comb begin
    ctrl = ucode_rom(step);
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl.cond)
      C_NONE:     taken = 1'b0;
      C_ALWAYS:   taken = 1'b1;
      C_NO_START: taken = !status.start;
      C_PTR_END:  taken = status.ptr_end;
      C_REQ_ALL:  taken = status.req_all;
      C_CLEAN:    taken = status.clean;
      default:    taken = 1'b1;
    endcase
    step_next = taken ? ctrl.target : step_t'(step + 1'b1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign busy = (step != S_IDLE);

  a_tail_to_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit == E_END |=> step == S_IDLE)
    else $error("sequencer did not return to idle after end frame");

  a_head_after_check: assert property (@(posedge clk) disable iff (rst)
    step == S_HEAD |-> $past(step) == S_CHECK)
    else $error("flush started without clean check");

endmodule

@@ rtl/apa102_dp.sv @@
// ----------------------------------------------------------------------------
// apa102_dp: frame store datapath
// Request latch, LED word build, pointer, frame store with valid bits,
// clean flag, count register and registered frame output.
// ----------------------------------------------------------------------------
module apa102_dp import apa102_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctrl,
  input  logic             start,
  input  req_t             req,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output status_t          status,
  output rsp_t             rsp,
  output logic             rsp_strobe
);

  logic [CNT_W-1:0]  led_count;
  logic [CNT_W-1:0]  active;
  logic [CNT_W-1:0]  ptr;
  logic              req_all;
  logic [31:0]       word;
  logic              store_clean;
  logic [MAX_LEDS-1:0] valid;
  logic              valid_q;
  logic [31:0]       ram_q;
  logic [31:0]       cur_word;
  logic              ram_we;
  logic [ADDR_W-1:0] addr;

  // Hold the count register
  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= COUNT_RESET;
    end else if (cfg_we) begin
      led_count <= cfg_wdata;
    end
  end

  // Saturate the count at the store size
  assign active = (led_count < CNT_W'(MAX_LEDS)) ? led_count : CNT_W'(MAX_LEDS);

  // Latch the request and its LED word
  always_ff @(posedge clk) begin
    if (ctrl.latch && start) begin
      req_all <= req.req_type;
      word    <= build_word(req);
    end
  end

  // Move the entry pointer
  always_ff @(posedge clk) begin
    case (ctrl.ptr_op)
      P_LOAD:  ptr <= req.req_type ? '0 : CNT_W'(req.led_index);
      P_CLEAR: ptr <= '0;
      P_INC:   ptr <= ptr + 1'b1;
      default: ptr <= ptr;
    endcase
  end

  assign addr = ptr[ADDR_W-1:0];

  // Frame store
  apa102_ram #(
    .WIDTH(32),
    .DEPTH(MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (word),
    .raddr (addr),
    .rdata (ram_q)
  );

  // Track written entries, unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid[addr];
      if (ram_we) begin
        valid[addr] <= 1'b1;
      end
    end
  end

  assign cur_word = valid_q ? ram_q : '0;
  assign ram_we   = ctrl.store && (cur_word != word);

  // Drop the clean flag on a changed word, set it when a flush starts
  always_ff @(posedge clk) begin
    if (rst) begin
      store_clean <= 1'b0;
    end else if (ram_we) begin
      store_clean <= 1'b0;
    end else if (ctrl.set_clean) begin
      store_clean <= 1'b1;
    end
  end

  // Register the outgoing frame
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_strobe <= 1'b0;
    end else begin
      rsp_strobe <= (ctrl.emit != E_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.emit)
      E_START: rsp.frame_word <= START_WORD;
      E_DATA:  rsp.frame_word <= cur_word;
      E_END:   rsp.frame_word <= END_WORD;
      default: rsp.frame_word <= rsp.frame_word;
    endcase
    rsp.last_frame <= (ctrl.emit == E_END);
  end

  assign status = '{start:   start,
                    ptr_end: (ptr >= active),
                    req_all: req_all,
                    clean:   store_clean};

  a_last_is_ones: assert property (@(posedge clk) disable iff (rst)
    rsp_strobe && rsp.last_frame |-> rsp.frame_word == END_WORD)
    else $error("end frame is not all ones");

  a_write_marks_dirty: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> !store_clean)
    else $error("store write left the store clean");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ptr < active)
    else $error("store write beyond the active count");

endmodule

@@ rtl/apa102_strip_frame_driver_top.sv @@
// ----------------------------------------------------------------------------
// apa102_strip_frame_driver_top: LED strip frame driver
// Keeps a frame store of LED words and emits a full strip frame sequence
// after every request that changed the store or is the first since reset.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req is taken at a clock edge with start high and busy low.
//   It sets one LED (req_type 0) or every active LED (req_type 1) to an RGB
//   or palette color with a brightness. If the store is then dirty, frames
//   follow on rsp, each valid for one cycle under rsp_strobe: a zero start
//   frame, one word per active LED and an all-ones end frame with last_frame
//   set. The receiver cannot stall; every strobe is a transfer. The user must
//   write led_count by cfg_we/cfg_wdata while the block is idle (not checked).
// Timing:
//   A single-LED request runs the read, store and clean check steps; a
//   set-all request repeats read and store per active LED. A flush adds the
//   head step, a fetch and a send step per active LED, a last fetch and the
//   tail step: every store entry passes the one registered read port over
//   two steps of the control program. The start frame is strobed in the
//   cycle after the head step; the next request is taken once busy drops.
// Reset:
//   rst clears the store to zero words, marks it dirty so the first request
//   flushes, and sets led_count to 32.
// ----------------------------------------------------------------------------
module apa102_strip_frame_driver_top import apa102_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             req,
  output rsp_t             rsp,
  output logic             rsp_strobe,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  ctrl_t   ctrl;
  status_t status;

  // Control program sequencer
  apa102_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Frame store datapath
  apa102_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .start      (start),
    .req        (req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .status     (status),
    .rsp        (rsp),
    .rsp_strobe (rsp_strobe)
  );

endmodule
